[sv/wpn_pkg.sv]
// Shared types, constants and tables of the waypoint guidance block.
package wpn_pkg;

  localparam int unsigned MAX_WAYPOINTS = 64;
  localparam int unsigned WP_IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned WP_CNT_W = $clog2(MAX_WAYPOINTS + 1);

  localparam logic signed [17:0] PI_Q     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_W     = 20;
  localparam int unsigned MUL_A_W      = 32;
  localparam int unsigned MUL_B_W      = 17;
  localparam int unsigned MUL_P_W      = MUL_A_W + MUL_B_W;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ODOM = 2'd1,
    CMD_FLAG = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_NAV_GAIN      = 3'd0,
    REG_GOAL_TOL      = 3'd1,
    REG_FWD_SPEED     = 3'd2,
    REG_MAX_TURN_RATE = 3'd3,
    REG_INV_TIME_STEP = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SQT,
    OP_RD,
    OP_ADV,
    OP_CINIT,
    OP_CITER,
    OP_DELTA,
    OP_M1,
    OP_M2,
    OP_RES
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_REACH,
    RES_FIN,
    RES_STEER
  } res_sel_e;

  typedef struct packed {
    dp_op_e     op;
    logic [3:0] iter;
    res_sel_e   sel;
  } dp_cmd_t;

  typedef struct packed {
    logic loaded;
    logic may_move;
    logic in_tol;
    logic at_end;
  } dp_status_t;

  // arctan(2^-i) in Q3.13
  function automatic logic [12:0] atan_lut(input logic [3:0] i);
    logic [12:0] r;
    unique case (i)
      4'd0:    r = 13'd6434;
      4'd1:    r = 13'd3798;
      4'd2:    r = 13'd2007;
      4'd3:    r = 13'd1019;
      4'd4:    r = 13'd511;
      4'd5:    r = 13'd256;
      4'd6:    r = 13'd128;
      4'd7:    r = 13'd64;
      4'd8:    r = 13'd32;
      4'd9:    r = 13'd16;
      4'd10:   r = 13'd8;
      4'd11:   r = 13'd4;
      4'd12:   r = 13'd2;
      4'd13:   r = 13'd1;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/wpn_if.sv]
// Item and result channel interfaces.
interface wpn_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               first_point;
  logic               last_point;
  logic               move_flag;

  modport source (output valid, command, pos_x, pos_y, first_point, last_point, move_flag,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, first_point, last_point, move_flag,
                output ready);
endinterface

interface wpn_out_if;
  logic               valid;
  logic               ready;
  logic [14:0]        lin_vel;
  logic signed [15:0] ang_vel;
  logic               reached;
  logic               finished;

  modport source (output valid, lin_vel, ang_vel, reached, finished, input ready);
  modport sink (input valid, lin_vel, ang_vel, reached, finished, output ready);
endinterface

[sv/wpn_ctrl.sv]
// Sequencer for tick processing and output register handshake.
module wpn_ctrl
  import wpn_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_command_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQT, S_CMP, S_RD, S_ADV,
    S_CINIT, S_CITER, S_DELTA, S_M1, S_M2, S_OUT
  } state_e;

  state_e     state_q, state_d;
  res_sel_e   sel_q, sel_d;
  logic [3:0] iter_q, iter_d;
  logic       valid_q, valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = valid_q;

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    iter_d     = iter_q;
    valid_d    = valid_q && !out_ready_i;
    cmd_o.op   = OP_NONE;
    cmd_o.iter = iter_q;
    cmd_o.sel  = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (in_command_i == CMD_TICK) begin
            if (status_i.loaded && status_i.may_move) begin
              state_d = S_DIFF;
            end else begin
              sel_d   = RES_ZERO;
              state_d = S_OUT;
            end
          end
        end
      end
      S_DIFF: begin cmd_o.op = OP_DIFF; state_d = S_SQX; end
      S_SQX:  begin cmd_o.op = OP_SQX;  state_d = S_SQY; end
      S_SQY:  begin cmd_o.op = OP_SQY;  state_d = S_SQT; end
      S_SQT:  begin cmd_o.op = OP_SQT;  state_d = S_CMP; end
      S_CMP: begin
        if (!status_i.in_tol) begin
          state_d = S_CINIT;
        end else if (status_i.at_end) begin
          sel_d   = RES_FIN;
          state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD:  begin cmd_o.op = OP_RD; state_d = S_ADV; end
      S_ADV: begin
        cmd_o.op = OP_ADV;
        sel_d    = RES_REACH;
        state_d  = S_OUT;
      end
      S_CINIT: begin
        cmd_o.op = OP_CINIT;
        iter_d   = '0;
        state_d  = S_CITER;
      end
      S_CITER: begin
        cmd_o.op = OP_CITER;
        iter_d   = iter_q + 4'd1;
        if (iter_q == 4'(CORDIC_STEPS - 1)) state_d = S_DELTA;
      end
      S_DELTA: begin cmd_o.op = OP_DELTA; state_d = S_M1; end
      S_M1:    begin cmd_o.op = OP_M1;    state_d = S_M2; end
      S_M2: begin
        cmd_o.op = OP_M2;
        sel_d    = RES_STEER;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.op = OP_RES;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= RES_ZERO;
      iter_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      iter_q  <= iter_d;
      valid_q <= valid_d;
    end
  end

endmodule

[sv/wpn_dp.sv]
// Datapath: waypoint table, guidance state, shared multiplier, CORDIC, result register.
module wpn_dp
  import wpn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [1:0]         command_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic               first_point_i,
  input  logic               last_point_i,
  input  logic               move_flag_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic [14:0]        lin_vel_o,
  output logic signed [15:0] ang_vel_o,
  output logic               reached_o,
  output logic               finished_o
);

  // configuration
  logic [15:0] nav_gain_q;
  logic [14:0] goal_tol_q, fwd_speed_q, max_turn_q;
  logic [15:0] inv_dt_q;

  // guidance state
  logic [WP_CNT_W-1:0] pt_q, ni_q;
  logic                loaded_q, may_move_q;
  logic [31:0]         goal_q, robot_q, first_xy_q;
  logic signed [15:0]  prev_q;

  // working registers
  logic [31:0]                 tbl [MAX_WAYPOINTS];
  logic [31:0]                 rdata_q;
  logic signed [16:0]          dx_q, dy_q;
  logic [MUL_P_W-1:0]          p_q;
  logic [33:0]                 acc_q;
  logic signed [CORDIC_W-1:0]  cx_q, cy_q;
  logic signed [16:0]          cz_q;
  logic                        zvec_q, neg_q;
  logic [16:0]                 mag_q;
  logic [14:0]                 lin_q;
  logic signed [15:0]          ang_q;
  logic                        reached_q, finished_q;

  logic                is_load;
  logic [WP_CNT_W-1:0] pt_eff, pt_new;
  logic                wr_en;
  logic [31:0]         xy;
  logic [16:0]         adx, ady;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic signed [CORDIC_W-1:0] xs, ys;
  logic signed [16:0]  atan_v;
  logic signed [17:0]  dlt_raw, dlt;
  logic [MUL_P_W-1:0]  rnd;
  logic [31:0]         magr;
  logic [14:0]         magc;

  assign xy      = {pos_y_i, pos_x_i};
  assign is_load = (cmd_i.op == OP_ACCEPT) && (command_i == CMD_LOAD) && !loaded_q;
  assign pt_eff  = first_point_i ? '0 : pt_q;
  assign wr_en   = is_load && (pt_eff < WP_CNT_W'(MAX_WAYPOINTS));
  assign pt_new  = wr_en ? pt_eff + 1'b1 : pt_eff;

  assign adx = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
  assign ady = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_SQX:  begin mul_a = MUL_A_W'(adx);        mul_b = adx; end
      OP_SQY:  begin mul_a = MUL_A_W'(ady);        mul_b = ady; end
      OP_SQT:  begin mul_a = MUL_A_W'(goal_tol_q); mul_b = MUL_B_W'(goal_tol_q); end
      OP_M1:   begin mul_a = MUL_A_W'(mag_q);      mul_b = MUL_B_W'(inv_dt_q); end
      OP_M2:   begin mul_a = p_q[MUL_A_W-1:0];     mul_b = MUL_B_W'(nav_gain_q); end
      default: begin mul_a = '0;                   mul_b = '0; end
    endcase
  end

  assign xs     = cx_q >>> cmd_i.iter;
  assign ys     = cy_q >>> cmd_i.iter;
  assign atan_v = 17'($signed({4'b0, atan_lut(cmd_i.iter)}));

  assign dlt_raw = {cz_q[16], cz_q} - 18'(prev_q);
  always_comb begin
    if (dlt_raw > PI_Q)       dlt = dlt_raw - TWO_PI_Q;
    else if (dlt_raw < -PI_Q) dlt = dlt_raw + TWO_PI_Q;
    else                      dlt = dlt_raw;
  end

  // round half up, then clamp to the turn-rate limit
  assign rnd  = p_q + MUL_P_W'(65536);
  assign magr = 32'(rnd[MUL_P_W-1:17]);
  assign magc = (magr > 32'(max_turn_q)) ? max_turn_q : magr[14:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nav_gain_q  <= 16'd1280;
      goal_tol_q  <= 15'd102;
      fwd_speed_q <= 15'd246;
      max_turn_q  <= 15'd4096;
      inv_dt_q    <= 16'd1280;
      pt_q        <= '0;
      ni_q        <= '0;
      loaded_q    <= 1'b0;
      goal_q      <= '0;
      robot_q     <= '0;
      may_move_q  <= 1'b1;
      prev_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NAV_GAIN:      nav_gain_q  <= cfg_data_i;
          REG_GOAL_TOL:      goal_tol_q  <= cfg_data_i[14:0];
          REG_FWD_SPEED:     fwd_speed_q <= cfg_data_i[14:0];
          REG_MAX_TURN_RATE: max_turn_q  <= cfg_data_i[14:0];
          REG_INV_TIME_STEP: inv_dt_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACCEPT) begin
        if (is_load) begin
          pt_q <= pt_new;
          if (first_point_i) ni_q <= '0;
          if (last_point_i && (pt_new != '0)) begin
            loaded_q <= 1'b1;
            goal_q   <= (pt_eff == '0) ? xy : first_xy_q;
          end
        end
        if (command_i == CMD_ODOM) robot_q    <= xy;
        if (command_i == CMD_FLAG) may_move_q <= move_flag_i;
      end
      if (cmd_i.op == OP_ADV) begin
        goal_q <= rdata_q;
        ni_q   <= ni_q + 1'b1;
      end
      if (cmd_i.op == OP_DELTA) prev_q <= cz_q[15:0];
      if (cmd_i.op == OP_RES && cmd_i.sel == RES_FIN) loaded_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl[pt_eff[WP_IDX_W-1:0]] <= xy;
    if (cmd_i.op == OP_RD) rdata_q <= tbl[ni_q[WP_IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (pt_eff == '0)) first_xy_q <= xy;
    unique case (cmd_i.op)
      OP_DIFF: begin
        dx_q <= 17'($signed(goal_q[15:0])) - 17'($signed(robot_q[15:0]));
        dy_q <= 17'($signed(goal_q[31:16])) - 17'($signed(robot_q[31:16]));
      end
      OP_SQX: p_q <= mul_a * mul_b;
      OP_SQY: begin
        acc_q <= 34'(p_q);
        p_q   <= mul_a * mul_b;
      end
      OP_SQT: begin
        acc_q <= acc_q + 34'(p_q);
        p_q   <= mul_a * mul_b;
      end
      OP_M1, OP_M2: p_q <= mul_a * mul_b;
      OP_CINIT: begin
        zvec_q <= (dx_q == '0) && (dy_q == '0);
        if (dx_q[16]) begin
          cx_q <= -CORDIC_W'(dx_q);
          cy_q <= -CORDIC_W'(dy_q);
          cz_q <= dy_q[16] ? -17'(PI_Q) : 17'(PI_Q);
        end else begin
          cx_q <= CORDIC_W'(dx_q);
          cy_q <= CORDIC_W'(dy_q);
          cz_q <= '0;
        end
      end
      OP_CITER: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          if (!zvec_q) cz_q <= cz_q + atan_v;
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          if (!zvec_q) cz_q <= cz_q - atan_v;
        end
      end
      OP_DELTA: begin
        neg_q <= dlt[17];
        mag_q <= dlt[17] ? 17'(-dlt) : 17'(dlt);
      end
      OP_RES: begin
        unique case (cmd_i.sel)
          RES_ZERO: begin
            lin_q <= '0; ang_q <= '0; reached_q <= 1'b0; finished_q <= 1'b0;
          end
          RES_REACH: begin
            lin_q <= '0; ang_q <= '0; reached_q <= 1'b1; finished_q <= 1'b0;
          end
          RES_FIN: begin
            lin_q <= '0; ang_q <= '0; reached_q <= 1'b1; finished_q <= 1'b1;
          end
          RES_STEER: begin
            lin_q      <= fwd_speed_q;
            ang_q      <= neg_q ? -$signed({1'b0, magc}) : $signed({1'b0, magc});
            reached_q  <= 1'b0;
            finished_q <= 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign status_o.loaded   = loaded_q;
  assign status_o.may_move = may_move_q;
  assign status_o.in_tol   = acc_q < 34'(p_q);
  assign status_o.at_end   = ni_q >= pt_q;

  assign lin_vel_o  = lin_q;
  assign ang_vel_o  = ang_q;
  assign reached_o  = reached_q;
  assign finished_o = finished_q;

endmodule

[sv/waypoint_pro_nav_guidance.sv]
// Top level of the proportional-navigation waypoint follower.
// Waypoint follower with proportional-navigation steering. Load items
// (command 0) append a waypoint to a 64-entry table while no trajectory is
// active; the item marked last activates the run with entry 0 as goal.
// Odometry (1) and move-flag (2) items update state and give no result. A
// tick (3) gives exactly one result transfer. A halted tick (stopped or
// nothing loaded) goes straight to its result; a tick that reaches the goal
// advances the goal along the table, unless it finishes the run; a steering
// tick runs the 16 iterations of the CORDIC atan2 unit and makes five
// passes through the single shared 32x17 multiplier (dx and dy squared,
// tolerance squared, then angle change times inverse time step and
// navigation gain). One item is worked at a time; the result sits in an
// output register so the next item is taken while it waits, and a tick
// that completes while that register is still full holds in its output
// state until the older result is transferred. Configuration writes are
// taken on any cycle with cfg_we_i high; indexes 5 to 7 are ignored.
module waypoint_pro_nav_guidance
  import wpn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  wpn_in_if.sink      in_ch,
  wpn_out_if.source   out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: accepts items, walks a tick through the datapath
  wpn_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_command_i (in_ch.command),
    .in_ready_o   (in_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // datapath: table, guidance state, multiplier, CORDIC, result register
  wpn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (in_ch.command),
    .pos_x_i       (in_ch.pos_x),
    .pos_y_i       (in_ch.pos_y),
    .first_point_i (in_ch.first_point),
    .last_point_i  (in_ch.last_point),
    .move_flag_i   (in_ch.move_flag),
    .cmd_i         (cmd),
    .status_o      (status),
    .lin_vel_o     (out_ch.lin_vel),
    .ang_vel_o     (out_ch.ang_vel),
    .reached_o     (out_ch.reached),
    .finished_o    (out_ch.finished)
  );

`ifndef SYNTHESIS
  // a finished run is always a reached goal
  a_fin_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.finished |-> out_ch.reached)
    else $error("finished without reached");

  // reaching the goal commands a standstill
  a_reach_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.reached |-> out_ch.lin_vel == '0 && out_ch.ang_vel == '0)
    else $error("nonzero velocity on reach");

  // a finishing result clears the active trajectory
  a_fin_unload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_RES && cmd.sel == RES_FIN |=> !status.loaded)
    else $error("trajectory still loaded after finish");
`endif

endmodule

[tb/sv/tb_waypoint_pro_nav_guidance.sv]
// Testbench for the proportional-navigation waypoint follower.
module tb_waypoint_pro_nav_guidance;
  import wpn_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  wpn_in_if  in_ch ();
  wpn_out_if out_ch ();

  waypoint_pro_nav_guidance dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // One guidance command as the block should issue it.
  typedef struct packed {
    logic [14:0]        lin_vel;
    logic signed [15:0] ang_vel;
    logic               reached;
    logic               finished;
  } steer_cmd_t;

  // Predictor copy of the block state and registers.
  logic [15:0] gain_q, inv_dt_q;
  logic [14:0] tol_q, speed_q, turn_max_q;
  logic [31:0] path_mem [MAX_WAYPOINTS];
  int unsigned path_len, path_next;
  bit          path_active, move_ok;
  logic [31:0] goal_pos, robot_pos;
  int          last_los;

  steer_cmd_t cmd_queue[$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         items_sent = 0;
  bit         idle_en = 1'b1;
  bit         hold_out = 1'b0;

  // Directed table row: item plus an optional hand-written expectation.
  typedef struct {
    cmd_e        cmd;
    logic [15:0] x, y;
    bit          fp, lp, mf;
    bit          has_exp;
    steer_cmd_t  exp;
  } stim_row_t;

  function automatic longint shr_floor(longint v, int s);
    return (v >= 0) ? (v >>> s) : ~((~v) >>> s);
  endfunction

  // Line-of-sight angle, Q3.13, vectoring CORDIC.
  function automatic int sight_angle(longint x, longint y);
    longint z, nx;
    int atn[16] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 25736 : -25736;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        y  = y - shr_floor(x, i);
        z += atn[i];
      end else begin
        nx = x - shr_floor(y, i);
        y  = y + shr_floor(x, i);
        z -= atn[i];
      end
      x = nx;
    end
    return int'(z);
  endfunction

  task automatic nav_reset();
    gain_q = 16'd1280; tol_q = 15'd102; speed_q = 15'd246;
    turn_max_q = 15'd4096; inv_dt_q = 16'd1280;
    foreach (path_mem[i]) path_mem[i] = '0;
    path_len = 0; path_next = 0; path_active = 0; move_ok = 1;
    goal_pos = '0; robot_pos = '0; last_los = 0;
  endtask

  // Advance the predictor by one item; ticks queue one expected command.
  task automatic nav_predict(cmd_e cmd, logic [15:0] x, logic [15:0] y,
                             bit fp, bit lp, bit mf);
    steer_cmd_t r;
    longint dx, dy, d2, tl, th, dl, mag;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        if (!path_active) begin
          if (fp) begin path_len = 0; path_next = 0; end
          if (path_len < MAX_WAYPOINTS) begin
            path_mem[path_len] = {y, x};
            path_len++;
          end
          if (lp && path_len > 0) begin
            path_active = 1;
            goal_pos = path_mem[0];
          end
        end
      end
      CMD_ODOM: robot_pos = {y, x};
      CMD_FLAG: move_ok = mf;
      default: begin
        if (move_ok && path_active) begin
          dx = longint'($signed(goal_pos[15:0])) - longint'($signed(robot_pos[15:0]));
          dy = longint'($signed(goal_pos[31:16])) - longint'($signed(robot_pos[31:16]));
          d2 = dx * dx + dy * dy;
          tl = tol_q;
          if (d2 < tl * tl) begin
            r.reached = 1;
            if (path_next >= path_len) begin
              path_active = 0;
              r.finished = 1;
            end else begin
              goal_pos = path_mem[path_next];
              path_next++;
            end
          end else begin
            th = sight_angle(dx, dy);
            dl = th - last_los;
            if (dl > 25736) dl -= 51472;
            if (dl < -25736) dl += 51472;
            last_los = int'(th);
            mag = (dl < 0) ? -dl : dl;
            mag = (mag * longint'(inv_dt_q) * longint'(gain_q) + 65536) >>> 17;
            if (mag > longint'(turn_max_q)) mag = turn_max_q;
            r.lin_vel = speed_q;
            r.ang_vel = 16'((dl < 0) ? -mag : mag);
          end
        end
        cmd_queue = {cmd_queue, r};
      end
    endcase
  endtask

  // Register write on the config port, mirrored into the predictor.
  task automatic reg_write(cfg_reg_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_NAV_GAIN:      gain_q = val;
      REG_GOAL_TOL:      tol_q = val[14:0];
      REG_FWD_SPEED:     speed_q = val[14:0];
      REG_MAX_TURN_RATE: turn_max_q = val[14:0];
      REG_INV_TIME_STEP: inv_dt_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Wait for every expected command, then allow for a trailing odometry/flag item.
  task automatic drain_wait();
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Offer one item; valid stays high across back-to-back transfers.
  task automatic send_item(cmd_e cmd, logic [15:0] x, logic [15:0] y,
                           bit fp, bit lp, bit mf);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.pos_x       <= x;
    in_ch.pos_y       <= y;
    in_ch.first_point <= fp;
    in_ch.last_point  <= lp;
    in_ch.move_flag   <= mf;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    // transfer happened at this edge; predict in transfer order
    nav_predict(cmd, x, y, fp, lp, mf);
    items_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Output checker: compare each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    steer_cmd_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (cmd_queue.size() == 0) begin
        $error("unexpected command transfer");
        fail_count++;
      end else begin
        e = cmd_queue.pop_front();
        if (out_ch.lin_vel !== e.lin_vel) begin
          $error("lin_vel expected %0d got %0d", e.lin_vel, out_ch.lin_vel);
          fail_count++;
        end
        if (out_ch.ang_vel !== e.ang_vel) begin
          $error("ang_vel expected %0d got %0d", e.ang_vel, out_ch.ang_vel);
          fail_count++;
        end
        if (out_ch.reached !== e.reached) begin
          $error("reached expected %0d got %0d", e.reached, out_ch.reached);
          fail_count++;
        end
        if (out_ch.finished !== e.finished) begin
          $error("finished expected %0d got %0d", e.finished, out_ch.finished);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_out = 0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 800000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Random items, biased toward well-formed trajectories around a random base point.
  task automatic send_random_path(int npts);
    logic [15:0] bx, by;
    bx = 16'($urandom);
    by = 16'($urandom);
    for (int k = 0; k < npts; k++)
      send_item(CMD_LOAD, bx + 16'($urandom_range(0, 4000)) - 16'd2000,
                by + 16'($urandom_range(0, 4000)) - 16'd2000,
                k == 0, k == npts - 1, 1'($urandom_range(0, 1)));
    // walk the robot toward each goal with ticks in between
    for (int k = 0; k < ((npts > 5) ? 8 : npts * 3 + 4); k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_item(CMD_TICK, 16'($urandom), 16'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        4: send_item(CMD_FLAG, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
        5: send_item(CMD_LOAD, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        6: send_item(CMD_ODOM, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: send_item(CMD_ODOM, goal_pos[15:0] + 16'($urandom_range(0, 80)) - 16'd40,
                           goal_pos[31:16] + 16'($urandom_range(0, 80)) - 16'd40,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
      endcase
      if ($urandom_range(0, 2) == 0)
        send_item(CMD_TICK, 16'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b0);
    end
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t mk(cmd_e c, int x, int y, bit fp, bit lp, bit mf,
                                   bit he = 0, steer_cmd_t ex = '0);
    stim_row_t r;
    r.cmd = c; r.x = 16'(x); r.y = 16'(y); r.fp = fp; r.lp = lp; r.mf = mf;
    r.has_exp = he; r.exp = ex;
    return r;
  endfunction

  task automatic add_row(stim_row_t r);
    dir_rows = {dir_rows, r};
  endtask

  // Hand-checked rows were also run through the predictor; undo that step by
  // replaying state, since the real transfer predicts it again.
  task automatic nav_reset_restore(int upto);
    steer_cmd_t saved[$];
    saved = cmd_queue;
    nav_reset();
    for (int j = 0; j < upto; j++)
      nav_predict(dir_rows[j].cmd, dir_rows[j].x, dir_rows[j].y,
                  dir_rows[j].fp, dir_rows[j].lp, dir_rows[j].mf);
    cmd_queue = saved;
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_LOAD;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.first_point <= 1'b0;
    in_ch.last_point <= 1'b0;
    in_ch.move_flag <= 1'b0;
    nav_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: halted tick after reset, tick during a partial load, extremes,
    // reach and finish, load while active, move-flag stop.
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, '0));
    add_row(mk(CMD_LOAD, 0, 0, 1, 0, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, '0));
    add_row(mk(CMD_LOAD, 32767, -32768, 1, 0, 0));
    add_row(mk(CMD_LOAD, -32768, 32767, 0, 1, 1));
    add_row(mk(CMD_LOAD, 5, 5, 1, 1, 1));
    add_row(mk(CMD_ODOM, -32768, 32767, 0, 0, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0));
    add_row(mk(CMD_ODOM, 32767, -32768, 1, 1, 1));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, steer_cmd_t'{15'd0, 16'sd0, 1'b1, 1'b0}));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, steer_cmd_t'{15'd0, 16'sd0, 1'b1, 1'b0}));
    add_row(mk(CMD_ODOM, -32768, 32767, 0, 0, 0));
    add_row(mk(CMD_TICK, -1, -1, 1, 1, 1, 1, steer_cmd_t'{15'd0, 16'sd0, 1'b1, 1'b1}));
    add_row(mk(CMD_FLAG, 0, 0, 0, 0, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, '0));
    add_row(mk(CMD_FLAG, 0, 0, 0, 0, 1));
    add_row(mk(CMD_ODOM, 0, 0, 0, 0, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0));
    add_row(mk(CMD_ODOM, -32768, 32767, 0, 0, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0));
    add_row(mk(CMD_ODOM, 32767, -32768, 0, 0, 0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, '0));
    add_row(mk(CMD_TICK, 0, 0, 0, 0, 0, 1, '0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        // the predictor must agree with the hand-written value
        nav_predict(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y,
                    dir_rows[i].fp, dir_rows[i].lp, dir_rows[i].mf);
        if (cmd_queue[$] !== dir_rows[i].exp) begin
          $error("directed row %0d: expected %h predicted %h", i, dir_rows[i].exp, cmd_queue[$]);
          fail_count++;
        end
        void'(cmd_queue.pop_back());
        nav_reset_restore(i);
      end
      send_item(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y,
                dir_rows[i].fp, dir_rows[i].lp, dir_rows[i].mf);
    end
    stop_sending();
    drain_wait();

    // Random part in phases with different register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          reg_write(REG_NAV_GAIN, 16'hFFFF); reg_write(REG_INV_TIME_STEP, 16'hFFFF);
          reg_write(REG_MAX_TURN_RATE, 16'h7FFF); reg_write(REG_GOAL_TOL, 16'd0);
          reg_write(REG_FWD_SPEED, 16'h7FFF);
        end
        1: begin
          reg_write(REG_NAV_GAIN, 16'd0); reg_write(REG_INV_TIME_STEP, 16'd0);
          reg_write(REG_MAX_TURN_RATE, 16'd0); reg_write(REG_GOAL_TOL, 16'h7FFF);
          reg_write(REG_FWD_SPEED, 16'd0);
        end
        default: begin
          reg_write(REG_NAV_GAIN, 16'($urandom));
          reg_write(REG_INV_TIME_STEP, 16'($urandom_range(0, 2000)));
          reg_write(REG_MAX_TURN_RATE, 16'($urandom_range(0, 32767)));
          reg_write(REG_GOAL_TOL, 16'($urandom_range(20, 3000)));
          reg_write(REG_FWD_SPEED, 16'($urandom_range(0, 32767)));
          cfg_we_i <= 1'b1; cfg_idx_i <= 3'd5 + 3'($urandom_range(0, 2));
          cfg_data_i <= 16'($urandom);
          @(posedge clk_i);
          cfg_we_i <= 1'b0;
        end
      endcase
      if (ph == 2) hold_out = 1;
      if (ph == 5) idle_en = 0;
      while (items_sent < (ph + 1) * 95 + 23) begin
        send_random_path($urandom_range(0, 3) == 0 ? $urandom_range(60, 66)
                                                   : $urandom_range(1, 5));
      end
      stop_sending();
      drain_wait();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
